[sv/srf_pkg.sv]
// Package for the scratch removal filter: sequencer states, request codes,
// register indexes and the pixel arithmetic helpers.
// Used by scratch_removal_filter; no dependencies.
package srf_pkg;

    localparam int DIM_W  = 8;
    localparam int PIX_W  = 24;
    localparam int CH_W   = 8;
    localparam int SUM_W  = 10;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_STRENGTH = 2'd0,
        REG_WIDTH    = 2'd1,
        REG_HEIGHT   = 2'd2,
        REG_UNUSED   = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDOUT,
        S_RA,
        S_RB,
        S_CMP,
        S_R1,
        S_R2,
        S_R3,
        S_WR,
        S_DONE
    } state_t;

    // (r + g + b) / 3, done as a multiply by 683 / 2048, exact for sums up to 765.
    function automatic logic [CH_W-1:0] bright(input logic [PIX_W-1:0] pix);
        logic [SUM_W-1:0] sum;
        logic [SUM_W+10-1:0] prod;
        begin
            sum  = SUM_W'(pix[23:16]) + SUM_W'(pix[15:8]) + SUM_W'(pix[7:0]);
            prod = (SUM_W+10)'(sum) * (SUM_W+10)'(683);
            bright = CH_W'(prod >> 11);
        end
    endfunction

endpackage

[sv/srf_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module srf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/scratch_removal_filter.sv]
// Scratch removal filter top level: pixel load and read-back, and the two
// in-place repair passes over the frame store. Depends on srf_pkg and srf_ram.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------
//  request   | req_valid / req_ready     | action, pos_x, pos_y, in_red/green/blue
//  result    | res_valid / res_ready     | out_red, out_green, out_blue, done_res
//  config    | cfg_we                    | cfg_index, cfg_data
//
// A run covers (w-1)*(h-1) pixel pairs in each of the two passes; every load,
// read-back and repair goes through the single frame store port. Reset sets the
// state, res_valid and the config registers; the datapath registers and the
// frame store are not cleared.
// A read or run whose result cannot leave waits in its last state and stalls
// further requests.
module scratch_removal_filter #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic [1:0]             action,
    input  logic [6:0]             pos_x,
    input  logic [6:0]             pos_y,
    input  logic [7:0]             in_red,
    input  logic [7:0]             in_green,
    input  logic [7:0]             in_blue,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic [7:0]             out_red,
    output logic [7:0]             out_green,
    output logic [7:0]             out_blue,
    output logic                   done_res,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [srf_pkg::DIM_W-1:0] cfg_data
);
    import srf_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IW     = ADDR_W + 2;
    localparam int LIN_W  = 16;

    logic [DIM_W-1:0] strength_reg, image_width_reg, image_height_reg;
    state_t state_reg, state_next;
    logic pass_reg, pass_next;
    logic [DIM_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [IW-1:0] p_reg, p_next, s_reg, s_next, n_reg, n_next;
    logic signed [IW-1:0] rd_idx_reg, rd_idx_next, step_reg, step_next;
    logic signed [IW-1:0] tgt_reg, tgt_next;
    logic rok_reg, rok_next;
    logic [PIX_W-1:0] a_reg, a_next;
    logic [SUM_W-1:0] acc_r_reg, acc_r_next, acc_g_reg, acc_g_next, acc_b_reg, acc_b_next;
    logic res_valid_reg, res_valid_next, done_reg, done_next;
    logic [CH_W-1:0] red_reg, red_next, green_reg, green_next, blue_reg, blue_next;

    logic ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0] ram_wdata, ram_rdata, rpix;

    logic [DIM_W-1:0] w_eff, h_eff, ba, bb;
    logic in_bounds, out_free, advance;
    logic [LIN_W-1:0] lin;
    logic signed [IW-1:0] start_idx;

    srf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign w_eff = (MAX_WIDTH < 256 && image_width_reg > DIM_W'(MAX_WIDTH)) ?
                   DIM_W'(MAX_WIDTH) : image_width_reg;
    assign h_eff = (MAX_HEIGHT < 256 && image_height_reg > DIM_W'(MAX_HEIGHT)) ?
                   DIM_W'(MAX_HEIGHT) : image_height_reg;
    assign in_bounds = (DIM_W'(pos_x) < w_eff) && (DIM_W'(pos_y) < h_eff);
    assign lin = LIN_W'(pos_y) * LIN_W'(w_eff) + LIN_W'(pos_x);
    assign out_free = !res_valid_reg || res_ready;
    assign rpix = rok_reg ? ram_rdata : '0;
    assign ba = bright(a_reg);
    assign bb = bright(ram_rdata);

    function automatic logic in_frame(input logic signed [IW-1:0] idx,
                                      input logic signed [IW-1:0] n);
        begin
            in_frame = (idx >= 0) && (idx < n);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg     <= DIM_W'(90);
            image_width_reg  <= DIM_W'(128);
            image_height_reg <= DIM_W'(128);
            state_reg        <= S_IDLE;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_STRENGTH: strength_reg     <= cfg_data;
                    REG_WIDTH:    image_width_reg  <= cfg_data;
                    REG_HEIGHT:   image_height_reg <= cfg_data;
                    default:      ;
                endcase
            end
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg   <= pass_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        p_reg      <= p_next;
        s_reg      <= s_next;
        n_reg      <= n_next;
        rd_idx_reg <= rd_idx_next;
        step_reg   <= step_next;
        tgt_reg    <= tgt_next;
        rok_reg    <= rok_next;
        a_reg      <= a_next;
        acc_r_reg  <= acc_r_next;
        acc_g_reg  <= acc_g_next;
        acc_b_reg  <= acc_b_next;
        done_reg   <= done_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        p_next         = p_reg;
        s_next         = s_reg;
        n_next         = n_reg;
        rd_idx_next    = rd_idx_reg;
        step_next      = step_reg;
        tgt_next       = tgt_reg;
        rok_next       = rok_reg;
        a_next         = a_reg;
        acc_r_next     = acc_r_reg;
        acc_g_next     = acc_g_reg;
        acc_b_next     = acc_b_reg;
        done_next      = done_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        res_valid_next = res_valid_reg && !res_ready;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = ADDR_W'(lin);
        ram_wdata      = {in_red, in_green, in_blue};
        req_ready      = 1'b0;
        advance        = 1'b0;
        start_idx      = p_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    case (action_t'(action))
                        ACT_WRITE:
                        begin
                            ram_we = in_bounds;
                        end
                        ACT_READ:
                        begin
                            ram_re     = 1'b1;
                            rok_next   = in_bounds;
                            state_next = S_RDOUT;
                        end
                        ACT_RUN:
                        begin
                            pass_next = 1'b0;
                            x_next    = '0;
                            y_next    = '0;
                            p_next    = '0;
                            s_next    = IW'(1);
                            n_next    = IW'(w_eff) * IW'(h_eff);
                            if (w_eff < DIM_W'(2) || h_eff < DIM_W'(2))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RA;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RDOUT:
            begin
                if (out_free)
                begin
                    red_next       = rpix[23:16];
                    green_next     = rpix[15:8];
                    blue_next      = rpix[7:0];
                    done_next      = 1'b0;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RA:
            begin
                ram_re     = 1'b1;
                ram_addr   = ADDR_W'(p_reg);
                state_next = S_RB;
            end
            S_RB:
            begin
                a_next     = ram_rdata;
                ram_re     = 1'b1;
                ram_addr   = ADDR_W'(p_reg + s_reg);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                acc_r_next = SUM_W'(a_reg[23:16]);
                acc_g_next = SUM_W'(a_reg[15:8]);
                acc_b_next = SUM_W'(a_reg[7:0]);
                if (bb > ba && (bb - ba) > strength_reg)
                begin
                    // The right or lower pixel is repaired from the darker side behind p.
                    tgt_next  = p_reg + s_reg;
                    step_next = -s_reg;
                    start_idx = p_reg - s_reg - s_reg;
                end
                else if (ba > bb && (ba - bb) > strength_reg)
                begin
                    tgt_next  = p_reg;
                    step_next = s_reg;
                    start_idx = p_reg + s_reg + s_reg;
                end
                if ((bb > ba && (bb - ba) > strength_reg) ||
                    (ba > bb && (ba - bb) > strength_reg))
                begin
                    ram_re      = 1'b1;
                    ram_addr    = ADDR_W'(start_idx);
                    rok_next    = in_frame(start_idx, n_reg);
                    rd_idx_next = start_idx + ((bb > ba) ? -s_reg : s_reg);
                    state_next  = S_R1;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_R1, S_R2, S_R3:
            begin
                acc_r_next = acc_r_reg + SUM_W'(rpix[23:16]);
                acc_g_next = acc_g_reg + SUM_W'(rpix[15:8]);
                acc_b_next = acc_b_reg + SUM_W'(rpix[7:0]);
                if (state_reg == S_R3)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    ram_re      = 1'b1;
                    ram_addr    = ADDR_W'(rd_idx_reg);
                    rok_next    = in_frame(rd_idx_reg, n_reg);
                    rd_idx_next = rd_idx_reg + step_reg;
                    state_next  = (state_reg == S_R1) ? S_R2 : S_R3;
                end
            end
            S_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = ADDR_W'(tgt_reg);
                ram_wdata = {CH_W'(acc_r_reg >> 2), CH_W'(acc_g_reg >> 2),
                             CH_W'(acc_b_reg >> 2)};
                advance   = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    red_next       = '0;
                    green_next     = '0;
                    blue_next      = '0;
                    done_next      = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Step to the next pair; the last column of each row is skipped.
        if (advance)
        begin
            state_next = S_RA;
            if (x_reg == w_eff - DIM_W'(2))
            begin
                x_next = '0;
                p_next = p_reg + IW'(2);
                if (y_reg == h_eff - DIM_W'(2))
                begin
                    y_next = '0;
                    p_next = '0;
                    if (pass_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pass_next = 1'b1;
                        s_next    = IW'(w_eff);
                    end
                end
                else
                begin
                    y_next = y_reg + DIM_W'(1);
                end
            end
            else
            begin
                x_next = x_reg + DIM_W'(1);
                p_next = p_reg + IW'(1);
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign done_res  = done_reg;

`ifndef ASSERT_OFF
    a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> out_red == 0 && out_green == 0 && out_blue == 0)
        else $error("run result carries pixel data");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE || state_reg == S_WR))
        else $error("frame store written outside load or repair");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(done_res) && $stable(out_red))
        else $error("pending result changed");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> !req_ready && !ram_we)
        else $error("request taken during a run");
`endif

endmodule
